### rtl/core/mbrf_pkg.sv
// package for the modbus read request framer
// holds the request word type, function codes, frame constants and the crc byte update
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mbrf_pkg;

  localparam int unsigned FrameLen = 8;
  localparam int unsigned IdxW     = $clog2(FrameLen);
  localparam int unsigned DataLenW = 17;
  localparam int unsigned RespLenW = 18;

  localparam logic [IdxW-1:0] LastIdx  = IdxW'(FrameLen - 1);
  localparam logic [IdxW-1:0] CrcLoIdx = IdxW'(FrameLen - 2);

  localparam logic [7:0] FcCoil        = 8'd1;
  localparam logic [7:0] FcInputStatus = 8'd2;
  localparam logic [7:0] FcHoldingReg  = 8'd3;
  localparam logic [7:0] FcInputReg    = 8'd4;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [RespLenW-1:0] RespOverhead = RespLenW'(5);

  typedef struct packed {
    logic [7:0]          addr;
    logic [7:0]          fc;
    logic [15:0]         start;
    logic [15:0]         qty;
    logic [RespLenW-1:0] resp_len;
  } req_t;

  // reflected crc-16 update over one byte, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/mbrf_req_stage.sv
// input register of the framer: captures a request and updates the kept data length
// depends on mbrf_pkg
`timescale 1ns / 1ps
`default_nettype none

module mbrf_req_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          slave_address_i,
  input  wire logic [7:0]          function_code_i,
  input  wire logic [15:0]         start_register_i,
  input  wire logic [15:0]         quantity_i,
  output logic                     req_valid_o,
  output mbrf_pkg::req_t           req_o,
  input  wire logic                req_take_i
);

  logic                                req_valid_q, req_valid_d;
  mbrf_pkg::req_t                      req_q, req_d;
  logic [mbrf_pkg::DataLenW-1:0]       data_len_q, data_len_d;
  logic                                accept;

  assign in_ready_o = !req_valid_q || req_take_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    data_len_d = data_len_q;
    unique case (function_code_i) inside
      mbrf_pkg::FcCoil, mbrf_pkg::FcInputStatus: begin
        // bytes needed to hold qty bits
        data_len_d = ({1'b0, quantity_i} + mbrf_pkg::DataLenW'(7)) >> 3;
      end
      mbrf_pkg::FcHoldingReg, mbrf_pkg::FcInputReg: begin
        data_len_d = {quantity_i, 1'b0};
      end
      default: begin
        data_len_d = data_len_q;
      end
    endcase
  end

  always_comb begin
    req_d.addr     = slave_address_i;
    req_d.fc       = function_code_i;
    req_d.start    = start_register_i;
    req_d.qty      = quantity_i;
    req_d.resp_len = {1'b0, data_len_d} + mbrf_pkg::RespOverhead;
  end

  always_comb begin
    req_valid_d = req_valid_q;
    if (accept) begin
      req_valid_d = 1'b1;
    end else if (req_take_i) begin
      req_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      data_len_q  <= '0;
    end else begin
      req_valid_q <= req_valid_d;
      if (accept) begin
        data_len_q <= data_len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_d;
    end
  end

  assign req_valid_o = req_valid_q;
  assign req_o       = req_q;

  // a take never happens without a held request
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_take_i |-> req_valid_q)
    else $error("take with empty request register");

  // data length moves only when a request comes in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(data_len_q))
    else $error("data length changed without a request");

  // a held request not taken stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q && !req_take_i |=> req_valid_q && $stable(req_q))
    else $error("held request lost");

endmodule

`default_nettype wire

### rtl/core/mbrf_serializer.sv
// frame serializer: steps through the eight frame bytes, folding the six bytes before the crc into it one byte per step
// depends on mbrf_pkg
`timescale 1ns / 1ps
`default_nettype none

module mbrf_serializer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           req_valid_i,
  input  wire mbrf_pkg::req_t                 req_i,
  output logic                                req_take_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [7:0]                          frame_byte_o,
  output logic [mbrf_pkg::IdxW-1:0]           byte_index_o,
  output logic                                last_byte_o,
  output logic [mbrf_pkg::RespLenW-1:0]       expected_response_len_o
);

  logic                              busy_q, busy_d;
  logic [mbrf_pkg::IdxW-1:0]         idx_q, idx_d;
  logic [15:0]                       crc_q, crc_d;
  logic [7:0]                        addr_q, fc_q;
  logic [15:0]                       start_m1_q, qty_q;
  logic [mbrf_pkg::RespLenW-1:0]     resp_q;

  logic                              out_valid_q, out_valid_d;
  logic [7:0]                        obyte_q;
  logic [mbrf_pkg::IdxW-1:0]         oidx_q;
  logic                              olast_q;
  logic [mbrf_pkg::RespLenW-1:0]     oresp_q;

  logic                              adv;
  logic                              load;
  logic [7:0]                        cur_byte;

  // one byte moves into the output register when it is empty or being drained
  assign adv  = busy_q && (!out_valid_q || out_ready_i);
  assign load = req_valid_i && (!busy_q || (adv && idx_q == mbrf_pkg::LastIdx));
  assign req_take_o = load;

  always_comb begin
    case (idx_q)
      3'd0:    cur_byte = addr_q;
      3'd1:    cur_byte = fc_q;
      3'd2:    cur_byte = start_m1_q[15:8];
      3'd3:    cur_byte = start_m1_q[7:0];
      3'd4:    cur_byte = qty_q[15:8];
      3'd5:    cur_byte = qty_q[7:0];
      3'd6:    cur_byte = crc_q[7:0];
      default: cur_byte = crc_q[15:8];
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    crc_d  = crc_q;
    if (adv) begin
      idx_d = idx_q + 1'b1;
      if (idx_q < mbrf_pkg::CrcLoIdx) begin
        crc_d = mbrf_pkg::crc_byte(crc_q, cur_byte);
      end
      if (idx_q == mbrf_pkg::LastIdx) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      idx_d  = '0;
      crc_d  = mbrf_pkg::CrcInit;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    if (load) begin
      addr_q     <= req_i.addr;
      fc_q       <= req_i.fc;
      start_m1_q <= req_i.start - 16'd1;
      qty_q      <= req_i.qty;
      resp_q     <= req_i.resp_len;
    end
    if (adv) begin
      obyte_q <= cur_byte;
      oidx_q  <= idx_q;
      olast_q <= (idx_q == mbrf_pkg::LastIdx);
      oresp_q <= resp_q;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign frame_byte_o            = obyte_q;
  assign byte_index_o            = oidx_q;
  assign last_byte_o             = olast_q;
  assign expected_response_len_o = oresp_q;

  // a new frame only starts when the previous one is done or sending its last byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !busy_q || idx_q == mbrf_pkg::LastIdx)
    else $error("frame restarted mid-way");

  // stalled frame keeps its position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !adv |=> busy_q && $stable(idx_q))
    else $error("frame position moved under stall");

  // bytes leave in order within a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && idx_q != mbrf_pkg::LastIdx |=> out_valid_q && oidx_q == $past(idx_q))
    else $error("byte index out of order");

  // the last byte flag goes with the final position only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (olast_q == (oidx_q == mbrf_pkg::LastIdx)))
    else $error("last flag on wrong position");

endmodule

`default_nettype wire

### rtl/core/modbus_read_request_framer.sv
// top level of the modbus rtu read request framer
// depends on mbrf_pkg, mbrf_req_stage and mbrf_serializer
//
// usage:
//   input channel (in_valid_i / in_ready_o) takes one read request word: slave
//   address, function code, one-based start register and quantity.
//   output channel (out_valid_o / out_ready_i) gives the eight frame bytes in send
//   order: address, function, start-1 (msb first), quantity (msb first), crc low,
//   crc high. last_byte_o marks the crc high byte. every byte carries the expected
//   response length (data bytes plus five); function codes other than 1..4 keep the
//   previous data length.
//   the first byte passes the input register, the serializer's field registers
//   and its output register. throughput: one byte per cycle while out_ready_i
//   holds no stall, set by the single byte-wide output port; the crc is folded
//   one byte per cycle under the same condition as the frame goes out.
//   the input register takes the next request while a frame is still being sent.
//   a stall on out_ready_i freezes the serializer in place; the input register
//   then fills and in_ready_o drops.
//   reset clears both valid flags and the kept data length to zero.
`timescale 1ns / 1ps
`default_nettype none

module modbus_read_request_framer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [7:0]                     slave_address_i,
  input  wire logic [7:0]                     function_code_i,
  input  wire logic [15:0]                    start_register_i,
  input  wire logic [15:0]                    quantity_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [7:0]                          frame_byte_o,
  output logic [2:0]                          byte_index_o,
  output logic                                last_byte_o,
  output logic [17:0]                         expected_response_len_o
);

  logic           req_valid;
  logic           req_take;
  mbrf_pkg::req_t req;

  mbrf_req_stage u_req_stage (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .slave_address_i  (slave_address_i),
    .function_code_i  (function_code_i),
    .start_register_i (start_register_i),
    .quantity_i       (quantity_i),
    .req_valid_o      (req_valid),
    .req_o            (req),
    .req_take_i       (req_take)
  );

  mbrf_serializer u_serializer (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .req_valid_i             (req_valid),
    .req_i                   (req),
    .req_take_o              (req_take),
    .out_valid_o             (out_valid_o),
    .out_ready_i             (out_ready_i),
    .frame_byte_o            (frame_byte_o),
    .byte_index_o            (byte_index_o),
    .last_byte_o             (last_byte_o),
    .expected_response_len_o (expected_response_len_o)
  );

endmodule

`default_nettype wire
